[hdl/sts_pkg.sv]
// shared constants and types of the subtitle tag stripper
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  // tag store geometry
  localparam int TagDepth = 63;
  localparam int TagAw    = $clog2(TagDepth);
  localparam int LenW     = $clog2(TagDepth + 1);
  // results of one item: up to the whole store plus one more byte
  localparam int ResW     = $clog2(TagDepth + 2);

  localparam logic [15:0] MaxCharsReset = 16'd511;

  // character codes
  localparam logic [7:0] CharLbrace = 8'h7B;
  localparam logic [7:0] CharRbrace = 8'h7D;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharP      = 8'h70;
  localparam logic [7:0] CharUpN    = 8'h4E;
  localparam logic [7:0] CharLowN   = 8'h6E;
  localparam logic [7:0] CharH      = 8'h68;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CharSpace  = 8'h20;

  // per-text parser state
  typedef struct packed {
    logic            inside_tag;
    logic            drawing;
    logic            bs_pend;
    logic            digits;
    logic [LenW-1:0] tag_len;
    logic            ov_seen;
  } sts_state_t;

  // decode of one byte: next state, tag store write, candidate characters
  typedef struct packed {
    sts_state_t       nxt;
    logic             wr_en;
    logic [TagAw-1:0] wr_addr;
    logic [1:0]       n_norm;
    logic [7:0]       norm0;
    logic [7:0]       norm1;
    logic [ResW-1:0]  tail_n;
    logic             tail_bs;
    logic             ov_end;
  } sts_dec_t;

endpackage

`default_nettype wire

[hdl/sts_tag_ram.sv]
// generic single-port-write, single-port-read synchronous ram
`timescale 1ns / 1ps
`default_nettype none

module sts_tag_ram #(
  parameter int Depth = 63,
  parameter int Width = 8,
  parameter int Aw    = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if ({1'b0, raddr_i} < (Aw + 1)'(Depth)) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/sts_decode.sv]
// byte decoder: parser state update and candidate characters for one byte
`timescale 1ns / 1ps
`default_nettype none

module sts_decode import sts_pkg::*; (
  input  wire sts_state_t st_i,
  input  wire logic [7:0] char_i,
  input  wire logic       last_i,
  output sts_dec_t        dec_o
);

  sts_state_t st;
  logic       fresh;
  logic [1:0] n;
  logic [7:0] e0;
  logic [7:0] e1;

  always_comb begin
    st    = st_i;
    fresh = 1'b0;
    n     = 2'd0;
    e0    = '0;
    e1    = '0;
    dec_o = '0;

    if (st.inside_tag) begin
      // keep the byte for a possible replay
      if (st.tag_len < LenW'(TagDepth)) begin
        dec_o.wr_en   = 1'b1;
        dec_o.wr_addr = st.tag_len[TagAw-1:0];
        st.tag_len    = st.tag_len + LenW'(1);
      end else begin
        st.ov_seen = 1'b1;
      end
      if (st.bs_pend) begin
        st.bs_pend = 1'b0;
        if (char_i == CharP) begin
          st.drawing = 1'b0;
          st.digits  = 1'b1;
        end else begin
          fresh = 1'b1;
        end
      end else if (st.digits) begin
        if (char_i >= CharZero && char_i <= CharNine) begin
          if (char_i != CharZero) begin
            st.drawing = 1'b1;
          end
        end else begin
          st.digits = 1'b0;
          fresh     = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end
      if (fresh) begin
        if (char_i == CharRbrace) begin
          st.inside_tag = 1'b0;
        end else if (char_i == CharBslash) begin
          st.bs_pend = 1'b1;
        end
      end
    end else begin
      if (!st.bs_pend) begin
        fresh = 1'b1;
      end else begin
        st.bs_pend = 1'b0;
        if (char_i == CharUpN || char_i == CharLowN) begin
          e0 = CharNl;
          n  = 2'd1;
        end else if (char_i == CharH) begin
          e0 = CharSpace;
          n  = 2'd1;
        end else begin
          // lone backslash is kept unless drawing
          if (!st.drawing) begin
            e0 = CharBslash;
            n  = 2'd1;
          end
          fresh = 1'b1;
        end
      end
      if (fresh) begin
        if (char_i == CharBslash) begin
          st.bs_pend = 1'b1;
        end else if (char_i == CharLbrace) begin
          st.inside_tag = 1'b1;
          dec_o.wr_en   = 1'b1;
          dec_o.wr_addr = '0;
          st.tag_len    = LenW'(1);
        end else if (!st.drawing) begin
          if (n == 2'd0) begin
            e0 = char_i;
          end else begin
            e1 = char_i;
          end
          n = n + 2'd1;
        end
      end
    end

    if (last_i) begin
      if (st.inside_tag) begin
        dec_o.tail_n = ResW'(st.tag_len);
        dec_o.ov_end = st.ov_seen;
      end else if (st.bs_pend && !st.drawing) begin
        dec_o.tail_bs = 1'b1;
        dec_o.tail_n  = ResW'(1);
      end
      st = '0;
    end

    dec_o.nxt    = st;
    dec_o.n_norm = n;
    dec_o.norm0  = e0;
    dec_o.norm1  = e1;
  end

endmodule

`default_nettype wire

[hdl/subtitle_tag_stripper.sv]
// top level of the subtitle tag stripper: byte parser, tag store and result sequencer
// result path: the first result moves through the job register and then the output
//   register, the latter loaded only while it is free
// throughput: one input transaction per cycle while each byte gives at most one result
//   and the output is free; a byte giving n results holds the input until its last
//   result leaves, one per cycle if unstalled; unclosed tags replay from the tag ram
// reset: asynchronous, clears parser state, counters and the sequencer; limit returns to 511
`timescale 1ns / 1ps
`default_nettype none

module subtitle_tag_stripper import sts_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // input bytes
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_char_i,
  input  wire logic        is_last_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             char_valid_o,
  output logic             end_of_text_o,
  output logic             output_cut_o,
  output logic             tag_store_overflow_o
);

  // configuration and per-text state
  logic [15:0] max_q, max_d;
  sts_state_t  st_q, st_d;
  logic [15:0] count_q, count_d;
  logic        cut_q, cut_d;

  // job register: results of the accepted byte waiting to be emitted
  logic            job_q, job_d;
  logic [ResW-1:0] k_q, k_d;
  logic [ResW-1:0] tot_q;
  logic            last_q;
  logic            bare_q;
  logic [1:0]      nn_q;
  logic [7:0]      c0_q;
  logic [7:0]      c1_q;
  logic            tbs_q;
  logic            ov_q;
  logic            mcut_q;
  logic            jcut_q;

  // replay read pointer and same-entry forwarding
  logic [LenW-1:0] rp_q, rp_d;
  logic [TagAw-1:0] rd_addr;
  logic            fwd_q, fwd_d;
  logic [7:0]      fwd_data_q;
  logic [7:0]      ram_rdata;
  logic [7:0]      rd_data;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_char_q;
  logic        char_valid_q;
  logic        eot_q;
  logic        cut_out_q;
  logic        ov_out_q;

  sts_dec_t        dec;
  logic            accept;
  logic [ResW-1:0] n_cand;
  logic [15:0]     avail;
  logic            over;
  logic [ResW-1:0] n_emit;
  logic            bare;
  logic            job_start;
  logic            load_ok;
  logic            final_res;
  logic            done;
  logic            is_norm;
  logic            is_rep;
  logic            tag_we;

  // result fields of the current job index
  logic [7:0] res_char;
  logic       res_cv;
  logic       res_cut;
  logic       res_ov;

  sts_decode u_decode (
    .st_i   (st_q),
    .char_i (in_char_i),
    .last_i (is_last_i),
    .dec_o  (dec)
  );

  sts_tag_ram #(
    .Depth (TagDepth),
    .Width (8)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (dec.wr_addr),
    .wdata_i (in_char_i),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;

  // the job register frees up in the cycle its final result moves out
  assign load_ok    = job_q && (!out_valid_q || out_ready_i);
  assign final_res  = (k_q == tot_q - ResW'(1));
  assign done       = load_ok && final_res;
  assign in_ready_o = !job_q || done;
  assign accept     = in_valid_i && in_ready_o;
  assign tag_we     = accept && dec.wr_en;

  // every candidate character passes while the limit allows, so the emitted ones
  // are a prefix of the candidates and their number is known up front
  assign n_cand    = ResW'(dec.n_norm) + dec.tail_n;
  assign avail     = (max_q > count_q) ? (max_q - count_q) : 16'd0;
  assign over      = 16'(n_cand) > avail;
  assign n_emit    = over ? avail[ResW-1:0] : n_cand;
  assign bare      = is_last_i && (n_emit == '0);
  assign job_start = accept && ((n_emit != '0) || is_last_i);

  assign is_norm = k_q < ResW'(nn_q);
  assign is_rep  = !bare_q && !is_norm && !tbs_q;

  // read address follows the next pointer so the registered data matches rp_q
  assign rd_addr = rp_d[TagAw-1:0];
  assign fwd_d   = tag_we && (dec.wr_addr == rd_addr);
  assign rd_data = fwd_q ? fwd_data_q : ram_rdata;

  always_comb begin
    res_char = '0;
    res_cv   = 1'b1;
    // emitted characters carry the cut flag as it stood before this byte
    res_cut  = jcut_q;
    res_ov   = 1'b0;
    if (bare_q) begin
      // bare end marker carries the cut flag and overflow of the text
      res_cv  = 1'b0;
      res_cut = mcut_q;
      res_ov  = ov_q;
    end else if (is_norm) begin
      res_char = k_q[0] ? c1_q : c0_q;
    end else if (tbs_q) begin
      res_char = CharBslash;
    end else begin
      res_char = rd_data;
      res_ov   = ov_q;
    end
  end

  always_comb begin
    max_d   = max_q;
    st_d    = st_q;
    count_d = count_q;
    cut_d   = cut_q;
    job_d   = job_q;
    k_d     = k_q;
    rp_d    = rp_q;

    if (cfg_valid_i && cfg_ready_o) begin
      max_d = cfg_data_i;
    end

    if (load_ok) begin
      k_d = k_q + ResW'(1);
      if (is_rep) begin
        rp_d = rp_q + LenW'(1);
      end
    end
    if (done) begin
      job_d = 1'b0;
    end

    if (accept) begin
      st_d = dec.nxt;
      if (is_last_i) begin
        count_d = '0;
        cut_d   = 1'b0;
      end else begin
        count_d = count_q + 16'(n_emit);
        cut_d   = cut_q | over;
      end
      k_d  = '0;
      rp_d = '0;
      if (job_start) begin
        job_d = 1'b1;
      end
    end
  end

  assign out_valid_d = load_ok ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MaxCharsReset;
      st_q        <= '0;
      count_q     <= '0;
      cut_q       <= 1'b0;
      job_q       <= 1'b0;
      k_q         <= '0;
      rp_q        <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      max_q       <= max_d;
      st_q        <= st_d;
      count_q     <= count_d;
      cut_q       <= cut_d;
      job_q       <= job_d;
      k_q         <= k_d;
      rp_q        <= rp_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // job and result payload
  always_ff @(posedge clk_i) begin
    fwd_data_q <= in_char_i;
    if (job_start) begin
      tot_q  <= bare ? ResW'(1) : n_emit;
      last_q <= is_last_i;
      bare_q <= bare;
      nn_q   <= dec.n_norm;
      c0_q   <= dec.norm0;
      c1_q   <= dec.norm1;
      tbs_q  <= dec.tail_bs;
      ov_q   <= dec.ov_end;
      mcut_q <= cut_q | over;
      jcut_q <= cut_q;
    end
    if (load_ok) begin
      out_char_q   <= res_char;
      char_valid_q <= res_cv;
      eot_q        <= last_q && final_res;
      cut_out_q    <= res_cut;
      ov_out_q     <= res_ov;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_char_o           = out_char_q;
  assign char_valid_o         = char_valid_q;
  assign end_of_text_o        = eot_q;
  assign output_cut_o         = cut_out_q;
  assign tag_store_overflow_o = ov_out_q;

endmodule

`default_nettype wire

[dv/plain_text_checker.sv]
// checker for the subtitle tag stripper: predicts the plain text output and compares it
`timescale 1ns / 1ps

module plain_text_checker import sts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_char_i,
  input  logic        is_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_i,
  input  logic        char_valid_i,
  input  logic        end_of_text_i,
  input  logic        output_cut_i,
  input  logic        tag_store_overflow_i,
  output int          err_count_o,
  output int          pending_o
);

  localparam int StepResultsMax = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       eot;
    logic       cut;
    logic       ov;
  } plain_out_t;

  plain_out_t stripped_q[$];

  // configuration and per-text parser state
  logic [15:0] char_limit;
  logic        in_tag;
  logic        drawing;
  logic        bs_pend;
  logic        digits;
  logic [15:0] emitted;
  logic [7:0]  tag_mem [TagDepth];
  int unsigned tag_len;
  logic        ov_seen;
  logic        cut_seen;
  int unsigned step_cnt;
  int unsigned result_idx;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    result_idx  = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s at result %0d: got %h, want %h",
             $realtime, what, result_idx, got, want);
    err_count_o++;
  endtask

  task automatic clear_text();
    in_tag   = 1'b0;
    drawing  = 1'b0;
    bs_pend  = 1'b0;
    digits   = 1'b0;
    emitted  = '0;
    tag_len  = 0;
    ov_seen  = 1'b0;
    cut_seen = 1'b0;
  endtask

  task automatic emit_char(input logic [7:0] c, input logic ov);
    plain_out_t r;
    if (step_cnt >= StepResultsMax) return;
    if (emitted >= char_limit) begin
      cut_seen = 1'b1;
      return;
    end
    r = '{ch: c, ch_valid: 1'b1, eot: 1'b0, cut: cut_seen, ov: ov};
    stripped_q.push_back(r);
    step_cnt++;
    emitted++;
  endtask

  task automatic keep_tag_byte(input logic [7:0] c);
    if (tag_len < TagDepth) begin
      tag_mem[tag_len] = c;
      tag_len++;
    end else begin
      ov_seen = 1'b1;
    end
  endtask

  task automatic plain_fresh(input logic [7:0] c);
    if (c == CharBslash) begin
      bs_pend = 1'b1;
    end else if (c == CharLbrace) begin
      in_tag  = 1'b1;
      tag_len = 0;
      keep_tag_byte(c);
    end else if (!drawing) begin
      emit_char(c, 1'b0);
    end
  endtask

  task automatic tag_fresh(input logic [7:0] c);
    if (c == CharRbrace) in_tag = 1'b0;
    else if (c == CharBslash) bs_pend = 1'b1;
  endtask

  // one byte in, its plain text results appended to the queue
  task automatic strip_byte(input logic [7:0] c, input logic last);
    logic       ov_end;
    plain_out_t r;
    ov_end   = 1'b0;
    step_cnt = 0;
    if (in_tag) begin
      keep_tag_byte(c);
      if (bs_pend) begin
        bs_pend = 1'b0;
        if (c == CharP) begin
          drawing = 1'b0;
          digits  = 1'b1;
        end else begin
          tag_fresh(c);
        end
      end else if (digits) begin
        if (c >= CharZero && c <= CharNine) begin
          if (c != CharZero) drawing = 1'b1;
        end else begin
          digits = 1'b0;
          tag_fresh(c);
        end
      end else begin
        tag_fresh(c);
      end
    end else if (bs_pend) begin
      bs_pend = 1'b0;
      if (c == CharUpN || c == CharLowN) begin
        emit_char(CharNl, 1'b0);
      end else if (c == CharH) begin
        emit_char(CharSpace, 1'b0);
      end else begin
        if (!drawing) emit_char(CharBslash, 1'b0);
        plain_fresh(c);
      end
    end else begin
      plain_fresh(c);
    end

    if (last) begin
      if (in_tag) begin
        ov_end = ov_seen;
        for (int i = 0; i < tag_len; i++) emit_char(tag_mem[i], ov_end);
      end else if (bs_pend && !drawing) begin
        emit_char(CharBslash, 1'b0);
      end
      if (step_cnt > 0) begin
        r     = stripped_q.pop_back();
        r.eot = 1'b1;
        stripped_q.push_back(r);
      end else begin
        r = '{ch: 8'h00, ch_valid: 1'b0, eot: 1'b1, cut: cut_seen, ov: ov_end};
        stripped_q.push_back(r);
      end
      clear_text();
    end
  endtask

  task automatic check_result();
    plain_out_t want;
    if (stripped_q.size() == 0) begin
      report_mismatch("unexpected result, out_char", out_char_i, 8'h00);
    end else begin
      want = stripped_q.pop_front();
      if (out_char_i !== want.ch) report_mismatch("out_char", out_char_i, want.ch);
      if (char_valid_i !== want.ch_valid)
        report_mismatch("char_valid", {7'd0, char_valid_i}, {7'd0, want.ch_valid});
      if (end_of_text_i !== want.eot)
        report_mismatch("end_of_text", {7'd0, end_of_text_i}, {7'd0, want.eot});
      if (output_cut_i !== want.cut)
        report_mismatch("output_cut", {7'd0, output_cut_i}, {7'd0, want.cut});
      if (tag_store_overflow_i !== want.ov)
        report_mismatch("tag_store_overflow", {7'd0, tag_store_overflow_i},
                        {7'd0, want.ov});
    end
    result_idx++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_limit = MaxCharsReset;
      clear_text();
      stripped_q.delete();
      pending_o = 0;
    end else begin
      // results leave before this edge's input is predicted
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) char_limit = cfg_data_i;
      if (in_valid_i && in_ready_i) strip_byte(in_char_i, is_last_i);
      pending_o = stripped_q.size();
    end
  end

endmodule

[dv/subtitle_tag_stripper_tb.sv]
// testbench top for the subtitle tag stripper: stimulus, idling and verdict
`timescale 1ns / 1ps

module subtitle_tag_stripper_tb;
  import sts_pkg::*;

  // receiver hold-off long enough to back the block up into its input
  localparam int LongHold = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_char_i;
  logic        is_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_char_o;
  logic        char_valid_o;
  logic        end_of_text_o;
  logic        output_cut_o;
  logic        tag_store_overflow_o;

  int          err_count;
  int          pending;

  // bytes of the text being assembled
  logic [7:0]  text_q[$];
  int unsigned items_sent;

  // idling controls; sink_gaps and hold_req are shared with the receiver process
  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_req;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  subtitle_tag_stripper uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .in_char_i            (in_char_i),
    .is_last_i            (is_last_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_char_o           (out_char_o),
    .char_valid_o         (char_valid_o),
    .end_of_text_o        (end_of_text_o),
    .output_cut_o         (output_cut_o),
    .tag_store_overflow_o (tag_store_overflow_o)
  );

  plain_text_checker u_plain_chk (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_i          (cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .in_char_i            (in_char_i),
    .is_last_i            (is_last_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_char_i           (out_char_o),
    .char_valid_i         (char_valid_o),
    .end_of_text_i        (end_of_text_o),
    .output_cut_i         (output_cut_o),
    .tag_store_overflow_i (tag_store_overflow_o),
    .err_count_o          (err_count),
    .pending_o            (pending)
  );

  task automatic add_byte(input logic [7:0] b);
    text_q.push_back(b);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // one input transaction; returns at the edge that accepts it, valid still high
  task automatic send_byte(input logic [7:0] c, input logic last);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    is_last_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sends the assembled text, last-byte mark on its final byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    items_sent += text_q.size();
    text_q.delete();
  endtask

  // limit changes only with the block drained and quiet
  task automatic write_limit(input logic [15:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a byte with no result may still be in flight
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // a short text built from plain letters, escapes, tags and stray bytes
  task automatic build_random_text();
    int unsigned ntok;
    ntok = $urandom_range(1, 3);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 9))
        0, 1: add_byte(8'h61 + 8'($urandom_range(0, 25)));
        2: add_byte(8'($urandom_range(0, 255)));
        3: begin
          // escape: newline, space or a lone backslash before something else
          add_byte(CharBslash);
          case ($urandom_range(0, 4))
            0: add_byte(CharUpN);
            1: add_byte(CharLowN);
            2: add_byte(CharH);
            3: add_byte(CharP);
            default: add_byte(8'($urandom_range(0, 255)));
          endcase
        end
        4, 5: begin
          // closed tag, mostly carrying a drawing switch
          add_byte(CharLbrace);
          if ($urandom_range(0, 2) != 0) begin
            add_byte(CharBslash);
            add_byte(CharP);
            repeat ($urandom_range(0, 2)) add_byte(CharZero + 8'($urandom_range(0, 9)));
          end
          repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
              0: add_byte(CharBslash);
              1: add_byte(CharH);
              2: add_byte(CharZero + 8'($urandom_range(0, 9)));
              default: add_byte(8'h62);
            endcase
          end
          add_byte(CharRbrace);
        end
        // tag with random body, often left open at the end of text
        6: begin
          add_byte(CharLbrace);
          repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
        end
        7: add_byte(CharBslash);
        8: add_byte($urandom_range(0, 1) ? CharRbrace : CharLbrace);
        default: add_byte(CharZero + 8'($urandom_range(0, 9)));
      endcase
    end
  endtask

  task automatic random_texts(input int unsigned n);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n) begin
      build_random_text();
      send_text();
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        for (int n = 0; n < LongHold; n++) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] b;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_char_i   = 8'h00;
    is_last_i   = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 16'h0000;
    items_sent  = 0;
    src_gaps    = 1'b1;
    sink_gaps   = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed texts at the reset limit
    // zero byte and all-ones byte are ordinary text
    add_byte(8'h00);
    add_byte(8'hFF);
    send_text();
    // newline and space escapes, then a lone backslash
    add_str("\\N\\h\\q");
    send_text();
    // drawing on hides text, drawing off shows it again
    add_str("{\\p1}a{\\p0}c");
    send_text();
    // backslash inside a tag is skipped, backslash as last byte is kept
    add_str("{\\x}\\");
    send_text();
    // unclosed tag is replayed from its brace
    add_str("x{ab");
    send_text();
    // final byte gives nothing: bare end marker
    add_str("{}");
    send_text();

    // widest limit
    write_limit(16'hFFFF);
    random_texts(4);

    // zero limit: every character is cut
    write_limit(16'h0000);
    random_texts(1);

    // tiny limit, cuts land inside texts and replays
    write_limit(16'd3);
    random_texts(3);

    // receiver holds off while an overflowing open tag streams in
    write_limit(16'd500);
    src_gaps = 1'b0;
    hold_req = 1'b1;
    add_byte(CharLbrace);
    repeat (63) begin
      b = 8'($urandom_range(0, 255));
      if (b == CharRbrace) b = CharSpace;
      add_byte(b);
    end
    send_text();
    random_texts(1);

    // last part runs without idling on either side
    write_limit(16'd40);
    sink_gaps = 1'b0;
    random_texts(3);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
hdl/sts_pkg.sv
hdl/sts_tag_ram.sv
hdl/sts_decode.sv
hdl/subtitle_tag_stripper.sv
dv/plain_text_checker.sv
dv/subtitle_tag_stripper_tb.sv
